[sv/base64_stream_decoder_unit_defines.svh]
// Assertion macros shared by the decoder RTL.
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define B64SD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define B64SD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/b64sd_pkg.sv]
package b64sd_pkg;

   localparam logic [7:0] PAD_SYMBOL = 8'h3D;   // '='
   localparam int MAX_RESULTS = 3;
   localparam int PUSH_COUNT_WIDTH = $clog2(MAX_RESULTS + 1);
   localparam int RESULT_DEPTH = 4;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       failed;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [PUSH_COUNT_WIDTH-1:0]  count;
      result_type [MAX_RESULTS-1:0] entry;
   } push_type;

   function automatic sextet_type sextet(input logic [7:0] c);
      sextet_type r;
      r.ok = 1'b1;
      r.value = '0;
      if (c >= 8'd65 && c <= 8'd90) begin
         r.value = 6'(c - 8'd65);
      end else if (c >= 8'd97 && c <= 8'd122) begin
         r.value = 6'(c - 8'd71);
      end else if (c >= 8'd48 && c <= 8'd57) begin
         r.value = 6'(c + 8'd4);
      end else if (c == 8'd43) begin
         r.value = 6'd62;
      end else if (c == 8'd47) begin
         r.value = 6'd63;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

[sv/b64sd_decode.sv]
`include "base64_stream_decoder_unit_defines.svh"

module b64sd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          symbol,
   input  logic                end_of_message,
   output b64sd_pkg::push_type push
);

   logic [7:0] held_ff [3];
   logic [1:0] pos_ff, pos_in;
   logic       err_ff, err_in;

   b64sd_pkg::sextet_type a, b, c, d;
   logic [5:0] cv, dv;
   logic [7:0] bytes [3];
   logic [b64sd_pkg::PUSH_COUNT_WIDTH-1:0] nbytes;
   logic bad, err_now;

   always_comb begin
      a = b64sd_pkg::sextet(held_ff[0]);
      b = b64sd_pkg::sextet(held_ff[1]);
      c = b64sd_pkg::sextet(held_ff[2]);
      d = b64sd_pkg::sextet(symbol);
      bad = 1'b0;
      nbytes = '0;
      if (pos_ff != 2'd3) begin
         bad = end_of_message;   // length not a multiple of four
      end else if (!a.ok || !b.ok) begin
         bad = 1'b1;
      end else if (!end_of_message) begin
         if (!c.ok || !d.ok) bad = 1'b1;
         else nbytes = 2'd3;
      end else if (held_ff[2] == b64sd_pkg::PAD_SYMBOL) begin
         nbytes = 2'd1;          // fourth char left unchecked
      end else if (!c.ok) begin
         bad = 1'b1;
      end else if (symbol == b64sd_pkg::PAD_SYMBOL) begin
         nbytes = 2'd2;
      end else if (!d.ok) begin
         bad = 1'b1;
      end else begin
         nbytes = 2'd3;
      end

      cv = c.ok ? c.value : 6'd0;
      dv = d.ok ? d.value : 6'd0;
      bytes[0] = {a.value, b.value[5:4]};
      bytes[1] = {b.value[3:0], cv[5:2]};
      bytes[2] = {cv[1:0], dv};
      err_now = err_ff | bad;

      for (int i = 0; i < b64sd_pkg::MAX_RESULTS; i++) begin
         push.entry[i].data_byte = bytes[i];
         push.entry[i].failed = 1'b0;
         push.entry[i].last = end_of_message &&
            (b64sd_pkg::PUSH_COUNT_WIDTH'(i + 1) == nbytes);
      end
      if (end_of_message && err_now) begin
         push.count = 2'd1;
         push.entry[0].data_byte = 8'd0;
         push.entry[0].failed = 1'b1;
         push.entry[0].last = 1'b1;
      end else if (err_now) begin
         push.count = '0;
      end else begin
         push.count = nbytes;
      end

      pos_in = (end_of_message || pos_ff == 2'd3) ? 2'd0 : pos_ff + 2'd1;
      err_in = end_of_message ? 1'b0 : err_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
         err_ff <= 1'b0;
      end else if (step) begin
         pos_ff <= pos_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (step && pos_ff == 2'(i)) held_ff[i] <= symbol;
      end
   end

   `B64SD_ASSERT_NEXT(a_eom_clears, clock, reset, step && end_of_message, pos_ff == 2'd0 && !err_ff, "state not cleared at message end")
   `B64SD_ASSERT_NOW(a_fail_alone, clock, reset, push.count != '0 && push.entry[0].failed, push.count == 2'd1 && push.entry[0].last, "error result not single and last")

endmodule

[sv/b64sd_result_fifo.sv]
`include "base64_stream_decoder_unit_defines.svh"

// Result queue taking up to MAX_RESULTS entries per cycle, one out per cycle while out_ready is high.
// DEPTH must be a power of two, at least MAX_RESULTS.
module b64sd_result_fifo #(
   parameter int DEPTH = b64sd_pkg::RESULT_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_en,
   input  b64sd_pkg::push_type   push,
   output logic                  fits,
   output logic                  out_valid,
   input  logic                  out_ready,
   output b64sd_pkg::result_type out_entry
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   b64sd_pkg::result_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [b64sd_pkg::PUSH_COUNT_WIDTH-1:0] push_n;
   logic pop;

   assign push_n = push_en ? push.count : '0;
   assign out_valid = count_ff != '0;
   assign out_entry = mem_ff[rd_ptr_ff];
   assign pop = out_valid && out_ready;
   assign fits = ((CntW + 1)'(count_ff) + (CntW + 1)'(push.count)) <= (CntW + 1)'(DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      count_in = count_ff + CntW'(push_n) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < b64sd_pkg::MAX_RESULTS; i++) begin
         if (b64sd_pkg::PUSH_COUNT_WIDTH'(i) < push_n) begin
            mem_ff[wr_ptr_ff + PtrW'(i)] <= push.entry[i];
         end
      end
   end

   `B64SD_ASSERT_NOW(a_no_overflow, clock, reset, push_en, fits, "result queue overflow")
   `B64SD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(DEPTH), "result count beyond depth")

endmodule

[sv/base64_stream_decoder_unit.sv]
// Base64 stream decoder.
// req_ channel: one character per transfer (req_symbol) with req_end_of_message
// on the final character of a message. rsp_ channel: decoded bytes, one per
// transfer, with rsp_failed and rsp_last. Every fourth character of a quad
// releases up to three bytes; a malformed message drops further bytes and
// closes with a single result carrying failed and last, data zero. Bytes
// already sent for such a message must be discarded by the consumer.
// A character is registered in the input register on transfer and decoded
// from there into the result queue once the queue has room; its bytes are
// offered from the queue. Throughput: one character per cycle, sustained, as
// long as the consumer takes one byte per cycle; the limit is the result queue,
// which must have room for all bytes of a quad before the quad is decoded.
// When the consumer stalls, the queue fills, the input register holds its
// character and req_ready drops until room returns.
// Reset (synchronous): clears the quad position, the error flag, the input
// register's valid flag and the queue; no clearing pass, ready once reset ends.
module base64_stream_decoder_unit #(
   parameter int RESULT_DEPTH = b64sd_pkg::RESULT_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_failed,
   output logic       rsp_last
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_symbol_ff;
   logic       s1_eom_ff;
   logic       fits, step, req_xfer;
   b64sd_pkg::push_type   push;
   b64sd_pkg::result_type front;

   assign step = s1_valid_ff && fits;
   assign req_ready = !s1_valid_ff || step;
   assign req_xfer = req_valid && req_ready;
   assign s1_valid_in = req_xfer || (s1_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_symbol_ff <= req_symbol;
         s1_eom_ff <= req_end_of_message;
      end
   end

   b64sd_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .symbol         (s1_symbol_ff),
      .end_of_message (s1_eom_ff),
      .push           (push)
   );

   b64sd_result_fifo #(
      .DEPTH (RESULT_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (step),
      .push      (push),
      .fits      (fits),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_entry (front)
   );

   assign rsp_data_byte = front.data_byte;
   assign rsp_failed = front.failed;
   assign rsp_last = front.last;

endmodule
